FILE: src/tmam_pkg.sv
// Shared types and constants for the tile map autotile mask block.
package tmam_pkg;

  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int ROW_LIMIT  = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int MAP_W      = 64;
  localparam int MAP_DEPTH  = 64;
  localparam int TILE_MAX   = 16;

  localparam int COORD_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int DIM_W      = 7;
  localparam int TILE_W     = 5;
  localparam int MASK_W     = 4;
  localparam int PIX_W      = 10;
  localparam int SHEET_W    = 8;

  // Request codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE = 2'd2;

  // Mask bit positions.
  localparam int NB_UP    = 0;
  localparam int NB_RIGHT = 1;
  localparam int NB_DOWN  = 2;
  localparam int NB_LEFT  = 3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;    // store one cell from the incoming item
    logic start;    // latch query, read row above and the row itself
    logic step_dn;  // hold row above, read row below
    logic load;     // build the result and load the output register
  } cmd_t;

endpackage

FILE: src/tmam_if.sv
// Channel interfaces: request items in, result items out.
interface tmam_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [5:0] col;
  logic [5:0] row;
  logic       solid;

  modport source(output valid, output req_type, output col, output row, output solid,
                 input ready);
  modport sink(input valid, input req_type, input col, input row, input solid,
               output ready);
endinterface

interface tmam_rsp_if;
  logic       valid;
  logic       ready;
  logic       cell_solid;
  logic [3:0] neighbor_mask;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;
  logic [7:0] sheet_x;
  logic       out_of_range;

  modport source(output valid, output cell_solid, output neighbor_mask, output pixel_x,
                 output pixel_y, output sheet_x, output out_of_range, input ready);
  modport sink(input valid, input cell_solid, input neighbor_mask, input pixel_x,
               input pixel_y, input sheet_x, input out_of_range, output ready);
endinterface

FILE: src/tmam_ctrl.sv
// Controller: sequences the row reads of a query and owns both handshakes.
module tmam_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_type,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output tmam_pkg::cmd_t cmd
);
  import tmam_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RD_DN = 3'b010,
    S_CALC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready    = (state == S_IDLE) && !rst;
  assign cmd.write   = in_ready && in_valid && (in_type == REQ_WRITE);
  assign cmd.start   = in_ready && in_valid && (in_type == REQ_QUERY);
  assign cmd.step_dn = (state == S_RD_DN);
  assign cmd.load    = (state == S_CALC) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (cmd.start) state_next = S_RD_DN;
      S_RD_DN: state_next = S_CALC;
      S_CALC:  if (cmd.load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

FILE: src/tmam_datapath.sv
// Datapath: config registers, cell map memory, neighbor mask and scaling.
module tmam_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  tmam_pkg::cmd_t                  cmd,
  input  logic                            cfg_we,
  input  logic [tmam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmam_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [tmam_pkg::COORD_W-1:0]    in_col,
  input  logic [tmam_pkg::COORD_W-1:0]    in_row,
  input  logic                            in_solid,
  output logic                            cell_solid,
  output logic [tmam_pkg::MASK_W-1:0]     neighbor_mask,
  output logic [tmam_pkg::PIX_W-1:0]      pixel_x,
  output logic [tmam_pkg::PIX_W-1:0]      pixel_y,
  output logic [tmam_pkg::SHEET_W-1:0]    sheet_x,
  output logic                            out_of_range
);
  import tmam_pkg::*;

  logic [DIM_W-1:0]   cols_reg;
  logic [DIM_W-1:0]   rows_reg;
  logic [TILE_W-1:0]  tile_reg;
  logic [DIM_W-1:0]   ncols;
  logic [DIM_W-1:0]   nrows;
  logic [TILE_W-1:0]  tsize;

  logic [MAP_W-1:0]     map_mem [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] row_valid;

  logic [COORD_W-1:0] item_col;
  logic [COORD_W-1:0] item_row;
  logic [COORD_W-1:0] addr_a;
  logic [MAP_W-1:0]   rd_a;
  logic [MAP_W-1:0]   rd_b;
  logic               vld_a;
  logic               vld_b;
  logic [MAP_W-1:0]   word_a;
  logic [MAP_W-1:0]   word_b;
  logic [MAP_W-1:0]   up_q;

  logic               wr_inside;
  logic               q_inside;
  logic [DIM_W-1:0]   col_p1;
  logic [DIM_W-1:0]   row_p1;
  logic [MASK_W-1:0]  mask;
  logic [10:0]        px_full;
  logic [10:0]        py_full;
  logic [8:0]         sx_full;

  // Clamp registers into their legal ranges.
  always_comb begin
    ncols = cols_reg;
    if (cols_reg == '0) ncols = DIM_W'(1);
    else if (cols_reg > DIM_W'(MAX_COLS)) ncols = DIM_W'(MAX_COLS);
    nrows = rows_reg;
    if (rows_reg == '0) nrows = DIM_W'(1);
    else if (rows_reg > DIM_W'(ROW_LIMIT)) nrows = DIM_W'(ROW_LIMIT);
    tsize = tile_reg;
    if (tile_reg == '0) tsize = TILE_W'(1);
    else if (tile_reg > TILE_W'(TILE_MAX)) tsize = TILE_W'(TILE_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_reg <= DIM_W'(64);
      rows_reg <= DIM_W'(36);
      tile_reg <= TILE_W'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS: cols_reg <= cfg_data;
        CFG_ROWS: rows_reg <= cfg_data;
        CFG_TILE: tile_reg <= cfg_data[TILE_W-1:0];
        default: ;
      endcase
    end
  end

  assign wr_inside = ({1'b0, in_col} < ncols) && ({1'b0, in_row} < nrows);

  // Row valid bits: a row not yet written reads as empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.write && wr_inside) begin
      row_valid[in_row] <= 1'b1;
    end
  end

  assign addr_a = cmd.start ? (in_row - COORD_W'(1)) : (item_row + COORD_W'(1));

  // Map memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.write && wr_inside) begin
      if (row_valid[in_row]) map_mem[in_row][in_col] <= in_solid;
      else map_mem[in_row] <= MAP_W'(in_solid) << in_col;
    end
    if (cmd.start || cmd.step_dn) begin
      rd_a  <= map_mem[addr_a];
      vld_a <= row_valid[addr_a];
    end
    if (cmd.start) begin
      rd_b  <= map_mem[in_row];
      vld_b <= row_valid[in_row];
    end
  end

  assign word_a = vld_a ? rd_a : '0;
  assign word_b = vld_b ? rd_b : '0;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_col <= in_col;
      item_row <= in_row;
    end
    if (cmd.step_dn) up_q <= word_a;
  end

  // Neighbor mask: port A now holds the row below, port B the row itself.
  always_comb begin
    col_p1 = {1'b0, item_col} + DIM_W'(1);
    row_p1 = {1'b0, item_row} + DIM_W'(1);
    q_inside = ({1'b0, item_col} < ncols) && ({1'b0, item_row} < nrows);
    mask[NB_UP]    = (item_row == '0) || up_q[item_col];
    mask[NB_RIGHT] = (col_p1 >= ncols) || word_b[col_p1[COORD_W-1:0]];
    mask[NB_DOWN]  = (row_p1 >= nrows) || word_a[item_col];
    mask[NB_LEFT]  = (item_col == '0) || word_b[item_col - COORD_W'(1)];
    px_full = 11'(item_col) * 11'(tsize);
    py_full = 11'(item_row) * 11'(tsize);
    sx_full = 9'(mask) * 9'(tsize);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (q_inside) begin
        cell_solid    <= word_b[item_col];
        neighbor_mask <= mask;
        pixel_x       <= px_full[PIX_W-1:0];
        pixel_y       <= py_full[PIX_W-1:0];
        sheet_x       <= sx_full[SHEET_W-1:0];
        out_of_range  <= 1'b0;
      end else begin
        cell_solid    <= 1'b0;
        neighbor_mask <= '0;
        pixel_x       <= '0;
        pixel_y       <= '0;
        sheet_x       <= '0;
        out_of_range  <= 1'b1;
      end
    end
  end

endmodule

FILE: src/tile_map_autotile_mask.sv
// Top level of the four-neighbor bitmask autotiler over a one-bit tile map.
//
// Channels: req carries write and query items (req_type, col, row, solid),
// rsp carries one result per query. Both use valid/ready; a transfer happens
// at a rising edge with valid and ready high. Writes give no result.
// cfg_we/cfg_index/cfg_data write cols_in_use (0), rows_in_use (1) and
// tile_size (2); write them only while the block is idle.
//
// Timing: req.ready stays high after a write and the next item may follow
// at once. A query runs in steps: the transfer edge reads the row above and
// the row itself, the read-down state reads the row below, and the calc
// state loads the result register once the output register is free.
// The registered memory read ports call for these steps. req.ready is low
// while a query is in flight.
//
// Reset (synchronous, rst high) holds req.ready low, loads the register
// defaults (64 columns, 36 rows, tile size 4) and marks all 64 map rows empty
// at once; no clearing pass. If the receiver stalls, the result holds in the
// output register; writes are still taken, and a further query waits in its
// last step until the register frees.
module tile_map_autotile_mask (
  input  logic                            clk,
  input  logic                            rst,
  tmam_req_if.sink                        req,
  tmam_rsp_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [tmam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmam_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tmam_pkg::*;

  cmd_t cmd;

  // Sequence the query steps and drive both handshakes.
  tmam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_type   (req.req_type),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Hold the map and registers, build the mask and scaled positions.
  tmam_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_col        (req.col),
    .in_row        (req.row),
    .in_solid      (req.solid),
    .cell_solid    (rsp.cell_solid),
    .neighbor_mask (rsp.neighbor_mask),
    .pixel_x       (rsp.pixel_x),
    .pixel_y       (rsp.pixel_y),
    .sheet_x       (rsp.sheet_x),
    .out_of_range  (rsp.out_of_range)
  );

  // A query in flight blocks the request side on the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && (req.req_type == REQ_QUERY) |=> !req.ready)
    else $error("request taken during a query");

  // An out-of-range result carries nothing but the flag.
  a_oor_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.out_of_range |->
      !rsp.cell_solid && (rsp.neighbor_mask == '0) && (rsp.sheet_x == '0) &&
      (rsp.pixel_x == '0) && (rsp.pixel_y == '0))
    else $error("out-of-range result with payload");

  // The left border always counts as solid.
  a_left_border: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.out_of_range && (rsp.pixel_x == '0) |-> rsp.neighbor_mask[NB_LEFT])
    else $error("left border not set in mask");

  // The top border always counts as solid.
  a_top_border: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.out_of_range && (rsp.pixel_y == '0) |-> rsp.neighbor_mask[NB_UP])
    else $error("top border not set in mask");

endmodule

FILE: tb/tile_map_autotile_mask_tb.sv
// Self-checking testbench for the tile map autotile mask block.
`timescale 1ns / 1ps

module tile_map_autotile_mask_tb;
  import tmam_pkg::*;

  // One request item and one result item, in the field order of the channels.
  typedef struct packed {
    logic       rt;
    logic [5:0] c;
    logic [5:0] r;
    logic       s;
  } tile_req_t;

  typedef struct packed {
    logic       cell_solid;
    logic [3:0] neighbor_mask;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic [7:0] sheet_x;
    logic       out_of_range;
  } tile_rsp_t;

  // A directed row either writes a register or sends one item. Rows with
  // has_exp set carry a hand-worked result; the rest go to the predictor.
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DATA_W-1:0]      val;
    tile_req_t                  item;
    logic                       has_exp;
    tile_rsp_t                  exp;
  } dir_row_t;

  localparam tile_rsp_t NO_EXP  = '0;
  localparam tile_rsp_t OUTSIDE = '{1'b0, 4'd0, 10'd0, 10'd0, 8'd0, 1'b1};

  // Neighbor offsets in mask bit order: up, right, down, left.
  localparam int NBR_DX [4] = '{0, 1, 0, -1};
  localparam int NBR_DY [4] = '{-1, 0, 1, 0};

  localparam int N_DIR       = 35;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 55;
  localparam int HOLD_CYCLES = 250;

  localparam dir_row_t DIR_TABLE [N_DIR] = '{
    // Defaults after reset: 64 x 36 map, tile size 4, all cells empty.
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd0, 6'd0, 1'b0}, 1'b1,
      '{1'b0, 4'd9, 10'd0, 10'd0, 8'd36, 1'b0}},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd63, 6'd35, 1'b0}, 1'b1,
      '{1'b0, 4'd6, 10'd252, 10'd140, 8'd24, 1'b0}},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd0, 6'd36, 1'b0}, 1'b1, OUTSIDE},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd63, 6'd63, 1'b1}, 1'b1, OUTSIDE},
    // Lone solid cell, then surround it on all four sides.
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_WRITE, 6'd10, 6'd10, 1'b1}, 1'b0, NO_EXP},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd10, 6'd10, 1'b0}, 1'b1,
      '{1'b1, 4'd0, 10'd40, 10'd40, 8'd0, 1'b0}},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_WRITE, 6'd10, 6'd9, 1'b1}, 1'b0, NO_EXP},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_WRITE, 6'd11, 6'd10, 1'b1}, 1'b0, NO_EXP},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_WRITE, 6'd10, 6'd11, 1'b1}, 1'b0, NO_EXP},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_WRITE, 6'd9, 6'd10, 1'b1}, 1'b0, NO_EXP},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd10, 6'd10, 1'b1}, 1'b1,
      '{1'b1, 4'd15, 10'd40, 10'd40, 8'd60, 1'b0}},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd10, 6'd9, 1'b0}, 1'b0, NO_EXP},
    // Empty cell still reports its mask and positions.
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_WRITE, 6'd10, 6'd10, 1'b0}, 1'b0, NO_EXP},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd10, 6'd10, 1'b0}, 1'b1,
      '{1'b0, 4'd15, 10'd40, 10'd40, 8'd60, 1'b0}},
    // Write below the bottom border is dropped; grow the map and look.
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_WRITE, 6'd5, 6'd40, 1'b1}, 1'b0, NO_EXP},
    '{ROW_CFG,  CFG_ROWS, 7'd64, '0, 1'b0, NO_EXP},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd5, 6'd40, 1'b0}, 1'b0, NO_EXP},
    // Shrink past stored cells; they must survive and come back.
    '{ROW_CFG,  CFG_COLS, 7'd10, '0, 1'b0, NO_EXP},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd9, 6'd10, 1'b0}, 1'b0, NO_EXP},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_WRITE, 6'd11, 6'd10, 1'b0}, 1'b0, NO_EXP},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd10, 6'd10, 1'b0}, 1'b1, OUTSIDE},
    '{ROW_CFG,  CFG_COLS, 7'd64, '0, 1'b0, NO_EXP},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd11, 6'd10, 1'b0}, 1'b0, NO_EXP},
    // Zero in every register acts as a 1 x 1 map with 1-pixel tiles.
    '{ROW_CFG,  CFG_COLS, 7'd0, '0, 1'b0, NO_EXP},
    '{ROW_CFG,  CFG_ROWS, 7'd0, '0, 1'b0, NO_EXP},
    '{ROW_CFG,  CFG_TILE, 7'd0, '0, 1'b0, NO_EXP},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd0, 6'd0, 1'b0}, 1'b1,
      '{1'b0, 4'd15, 10'd0, 10'd0, 8'd15, 1'b0}},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd1, 6'd0, 1'b0}, 1'b1, OUTSIDE},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd0, 6'd1, 1'b0}, 1'b1, OUTSIDE},
    // Oversized registers saturate at 64 x 64 and tile size 16.
    '{ROW_CFG,  CFG_COLS, 7'd127, '0, 1'b0, NO_EXP},
    '{ROW_CFG,  CFG_ROWS, 7'd127, '0, 1'b0, NO_EXP},
    '{ROW_CFG,  CFG_TILE, 7'd31, '0, 1'b0, NO_EXP},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd63, 6'd63, 1'b1}, 1'b1,
      '{1'b0, 4'd6, 10'd1008, 10'd1008, 8'd96, 1'b0}},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_WRITE, 6'd63, 6'd63, 1'b1}, 1'b0, NO_EXP},
    '{ROW_ITEM, CFG_COLS, 7'd0, '{REQ_QUERY, 6'd62, 6'd63, 1'b0}, 1'b0, NO_EXP}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tmam_req_if req_ch ();
  tmam_rsp_if rsp_ch ();

  tile_map_autotile_mask uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block: the map and the raw register contents.
  logic [MAP_W-1:0]  shadow_map [MAP_DEPTH];
  logic [DIM_W-1:0]  cols_reg = 7'd64;
  logic [DIM_W-1:0]  rows_reg = 7'd36;
  logic [TILE_W-1:0] tile_reg = 5'd4;

  tile_rsp_t pending_tiles [$];

  int mismatch_count  = 0;
  int result_count    = 0;
  int query_count     = 0;
  int write_count     = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_requests   = 0;
  int setting_count   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case a transfer never completes.
  initial begin
    #400_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int clamp_reg(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit cell_in_map(input int c, input int r);
    return c < clamp_reg(cols_reg, MAX_COLS) && r < clamp_reg(rows_reg, ROW_LIMIT);
  endfunction

  // Expected result of a query against the shadow map and registers.
  function automatic tile_rsp_t predict_tile(input logic [5:0] c, input logic [5:0] r);
    int        ncols;
    int        nrows;
    int        ts;
    int        nx;
    int        ny;
    logic [3:0] m;
    tile_rsp_t res;
    ncols = clamp_reg(cols_reg, MAX_COLS);
    nrows = clamp_reg(rows_reg, ROW_LIMIT);
    ts    = clamp_reg(tile_reg, TILE_MAX);
    res   = '0;
    m     = '0;
    if (!cell_in_map(c, r)) begin
      res.out_of_range = 1'b1;
      return res;
    end
    // A side counts as solid when it is off the map in use.
    for (int d = NB_UP; d <= NB_LEFT; d++) begin
      nx = int'(c) + NBR_DX[d];
      ny = int'(r) + NBR_DY[d];
      if (nx < 0 || ny < 0 || nx >= ncols || ny >= nrows || shadow_map[ny][nx])
        m[d] = 1'b1;
    end
    res.cell_solid    = shadow_map[r][c];
    res.neighbor_mask = m;
    res.pixel_x       = 10'(int'(c) * ts);
    res.pixel_y       = 10'(int'(r) * ts);
    res.sheet_x       = 8'(int'(m) * ts);
    return res;
  endfunction

  // Random item: mostly inside the map in use so queries meet real neighbors,
  // the rest anywhere in the coordinate range.
  function automatic tile_req_t next_random_req();
    tile_req_t it;
    it.rt = ($urandom_range(99) < 55) ? REQ_QUERY : REQ_WRITE;
    if ($urandom_range(99) < 90) begin
      it.c = 6'($urandom_range(clamp_reg(cols_reg, MAX_COLS) - 1));
      it.r = 6'($urandom_range(clamp_reg(rows_reg, ROW_LIMIT) - 1));
    end else begin
      it.c = 6'($urandom_range(63));
      it.r = 6'($urandom_range(63));
    end
    it.s = ($urandom_range(99) < 60);
    return it;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t result %0d: %s", $time, result_count, msg);
    mismatch_count++;
  endtask

  // Offer one item and hold it until the transfer; then update the shadow.
  // Call right after a rising edge.
  task automatic push_item(input tile_req_t it, input bit has_exp, input tile_rsp_t exp);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= it.rt;
    req_ch.col      <= it.c;
    req_ch.row      <= it.r;
    req_ch.solid    <= it.s;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (it.rt == REQ_QUERY) begin
      pending_tiles.push_back(has_exp ? exp : predict_tile(it.c, it.r));
      query_count++;
    end else begin
      if (cell_in_map(it.c, it.r)) shadow_map[it.r][it.c] = it.s;
      write_count++;
    end
  endtask

  // Drop valid for a random stretch; scramble the idle payload.
  task automatic idle_gap();
    if ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= 1'($urandom_range(1));
      req_ch.col      <= 6'($urandom_range(63));
      req_ch.row      <= 6'($urandom_range(63));
      req_ch.solid    <= 1'($urandom_range(1));
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
  endtask

  // Stop sending, wait for every pending result, then let a write that was
  // just taken settle inside the block.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_COLS: cols_reg = val;
      CFG_ROWS: rows_reg = val;
      CFG_TILE: tile_reg = val[TILE_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input int c, input int r, input int t);
    drain_results();
    write_reg(CFG_COLS, 7'(c));
    write_reg(CFG_ROWS, 7'(r));
    write_reg(CFG_TILE, 7'(t));
    setting_count++;
  endtask

  // Receiver: random stalls per the current phase, plus long hold-offs that
  // the stimulus asks for and this process counts down itself.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each result transfer with the oldest pending expectation.
  always @(posedge clk) begin : check_results
    tile_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_tiles.size() == 0) begin
        flag_mismatch("result with nothing pending");
      end else begin
        want = pending_tiles.pop_front();
        if (rsp_ch.cell_solid !== want.cell_solid)
          flag_mismatch($sformatf("cell_solid %b, want %b", rsp_ch.cell_solid,
                                  want.cell_solid));
        if (rsp_ch.neighbor_mask !== want.neighbor_mask)
          flag_mismatch($sformatf("neighbor_mask %b, want %b", rsp_ch.neighbor_mask,
                                  want.neighbor_mask));
        if (rsp_ch.pixel_x !== want.pixel_x)
          flag_mismatch($sformatf("pixel_x %0d, want %0d", rsp_ch.pixel_x, want.pixel_x));
        if (rsp_ch.pixel_y !== want.pixel_y)
          flag_mismatch($sformatf("pixel_y %0d, want %0d", rsp_ch.pixel_y, want.pixel_y));
        if (rsp_ch.sheet_x !== want.sheet_x)
          flag_mismatch($sformatf("sheet_x %0d, want %0d", rsp_ch.sheet_x, want.sheet_x));
        if (rsp_ch.out_of_range !== want.out_of_range)
          flag_mismatch($sformatf("out_of_range %b, want %b", rsp_ch.out_of_range,
                                  want.out_of_range));
      end
      result_count++;
    end
  end

  initial begin : stimulus
    int c;
    int r;
    int t;
    int random_items;
    random_items = 0;
    foreach (shadow_map[i]) shadow_map[i] = '0;

    // Drive every input to a known value before the first edge.
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = CFG_COLS;
    cfg_data        = '0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_WRITE;
    req_ch.col      = '0;
    req_ch.row      = '0;
    req_ch.solid    = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    setting_count = 1;

    // Directed part: walk the table back to back.
    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_TABLE[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(DIR_TABLE[i].idx, DIR_TABLE[i].val);
        setting_count++;
      end else begin
        push_item(DIR_TABLE[i].item, DIR_TABLE[i].has_exp, DIR_TABLE[i].exp);
      end
    end

    // Random part: one register setting per phase, rotating the idle pattern.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin c = 64;  r = 36;  t = 4;  end
        1: begin c = 5;   r = 4;   t = 3;  end
        2: begin c = 1;   r = 1;   t = 1;  end
        3: begin c = 64;  r = 64;  t = 16; end
        4: begin c = 8;   r = 8;   t = 16; end
        5: begin c = 0;   r = 0;   t = 0;  end
        6: begin c = 127; r = 127; t = 31; end
        7: begin c = 2;   r = 3;   t = 7;  end
        8: begin
          c = $urandom_range(127);
          r = $urandom_range(127);
          t = $urandom_range(31);
        end
        default: begin
          c = $urandom_range(1, 12);
          r = $urandom_range(1, 12);
          t = $urandom_range(1, 16);
        end
      endcase
      apply_config(c, r, t);

      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin sender_idle_pct = 33; recv_stall_pct = 33; end
      endcase

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Hold the receiver off while the sender keeps pushing at full rate.
        if (ph == 4 && k == 10) hold_requests++;
        // Pause the sender once until every pending result is back.
        if (ph == 7 && k == 30) drain_results();
        push_item(next_random_req(), 1'b0, NO_EXP);
        random_items++;
        idle_gap();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d directed and %0d random items (%0d queries, %0d writes) over %0d settings.",
             N_DIR - setting_count + NUM_PHASES + 1, random_items, query_count, write_count,
             setting_count);
    $display("Checked %0d results, %0d mismatches.", result_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
